/* src/ipdfr_pkg.sv */
package ipdfr_pkg;

    localparam int PAYLOAD_LIMIT_DEF = 256;
    localparam int COUNT_WRAP        = 16384;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_BYTE     = 3'd1;
    localparam logic [2:0] EV_CR_ARMED = 3'd2;
    localparam logic [2:0] EV_DONE     = 3'd3;
    localparam logic [2:0] EV_ABORT    = 3'd4;
    localparam logic [2:0] EV_OVERFLOW = 3'd5;

endpackage

/* src/ipd_frame_receiver.sv */
// Channel  Signals                       Direction  Request content
// rx       rx_valid, rx_stall, rx_byte   in         one received serial byte
// ev       ev_valid, ev_stall, event_*   out        one event per received byte
//
// One request per cycle while rx_stall is low; each event appears in the cycle after its byte is taken.
// The parser state and the event register update in the same clock edge.
// rst_n clears the parser to hunting for '+' and empties the event register.
// rx_stall rises only while an event waits and ev_stall is high; the byte
// and event paths then hold until the event is taken.
module ipd_frame_receiver #(
    parameter int PAYLOAD_LIMIT = ipdfr_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       ev_valid,
    input  logic       ev_stall,
    output logic [2:0] event_kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] frame_length
);
    import ipdfr_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_LIMIT);
    localparam logic [CNT_W:0] LIMIT_VAL = (CNT_W + 1)'(PAYLOAD_LIMIT);
    localparam bit LIMIT_WRAPS = (PAYLOAD_LIMIT == COUNT_WRAP);

    typedef enum logic [2:0] {
        ST_HUNT  = 3'd0,
        ST_I     = 3'd1,
        ST_P     = 3'd2,
        ST_D     = 3'd3,
        ST_COMMA = 3'd4,
        ST_DATA  = 3'd5
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             armed_reg, armed_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [2:0]       kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic [7:0]       index_reg, index_next;
    logic [7:0]       length_reg, length_next;
    logic [CNT_W:0]   count_inc;
    logic             accept;

    assign rx_stall = ev_valid_reg && ev_stall;
    assign accept   = rx_valid && !rx_stall;
    assign count_inc = {1'b0, count_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        armed_next    = armed_reg;
        ev_valid_next = ev_valid_reg && ev_stall;
        kind_next     = kind_reg;
        byte_next     = byte_reg;
        index_next    = index_reg;
        length_next   = length_reg;
        if (accept)
        begin
            ev_valid_next = 1'b1;
            kind_next     = EV_NONE;
            byte_next     = '0;
            index_next    = '0;
            length_next   = '0;
            unique case (state_reg)
                ST_I:     state_next = (rx_byte == CH_I)     ? ST_P     : ST_HUNT;
                ST_P:     state_next = (rx_byte == CH_P)     ? ST_D     : ST_HUNT;
                ST_D:     state_next = (rx_byte == CH_D)     ? ST_COMMA : ST_HUNT;
                ST_COMMA: state_next = (rx_byte == CH_COMMA) ? ST_DATA  : ST_HUNT;
                ST_DATA:
                begin
                    if (armed_reg)
                    begin
                        if (rx_byte == CH_LF)
                        begin
                            kind_next   = EV_DONE;
                            length_next = 8'(count_reg);
                            state_next  = ST_HUNT;
                        end
                        else
                        begin
                            kind_next = EV_ABORT;
                        end
                        count_next = '0;
                        armed_next = 1'b0;
                    end
                    else if (rx_byte == CH_CR && count_reg > CNT_W'(1))
                    begin
                        armed_next = 1'b1;
                        kind_next  = EV_CR_ARMED;
                    end
                    else
                    begin
                        byte_next  = rx_byte;
                        index_next = 8'(count_reg);
                        if (count_inc == LIMIT_VAL)
                        begin
                            count_next = '0;
                            kind_next  = LIMIT_WRAPS ? EV_BYTE : EV_OVERFLOW;
                        end
                        else
                        begin
                            count_next = count_inc[CNT_W-1:0];
                            kind_next  = EV_BYTE;
                        end
                    end
                end
                default:  state_next = (rx_byte == CH_PLUS)  ? ST_I     : ST_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HUNT;
            count_reg    <= '0;
            armed_reg    <= 1'b0;
            ev_valid_reg <= 1'b0;
            kind_reg     <= EV_NONE;
            byte_reg     <= '0;
            index_reg    <= '0;
            length_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            armed_reg    <= armed_next;
            ev_valid_reg <= ev_valid_next;
            kind_reg     <= kind_next;
            byte_reg     <= byte_next;
            index_reg    <= index_next;
            length_reg   <= length_next;
        end
    end

    assign ev_valid      = ev_valid_reg;
    assign event_kind    = kind_reg;
    assign payload_byte  = byte_reg;
    assign payload_index = index_reg;
    assign frame_length  = length_reg;

endmodule

/* src/ipdfr_checker.sv */
module ipdfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_stall,
    input logic       ev_valid,
    input logic       ev_stall,
    input logic [2:0] event_kind,
    input logic [7:0] frame_length
);
    import ipdfr_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> ev_valid && ev_stall)
        else $error("rx stalled without a blocked event");

    assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && !rx_stall |=> ev_valid)
        else $error("accepted byte produced no event");

    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_stall |=> ev_valid && $stable(event_kind) && $stable(frame_length))
        else $error("stalled event changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind != EV_DONE |-> frame_length == 8'd0)
        else $error("frame length outside frame done");

    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> event_kind <= EV_OVERFLOW)
        else $error("undefined event kind");

endmodule

bind ipd_frame_receiver ipdfr_checker u_ipdfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .ev_valid     (ev_valid),
    .ev_stall     (ev_stall),
    .event_kind   (event_kind),
    .frame_length (frame_length)
);
